// ===== hdl/ossr_pkg.sv =====
// Shared types, constants and microcode ROM for the order-statistic select/remove block.
`default_nettype none

package ossr_pkg;

  localparam int MAX_SLOTS_DEF = 1024;

  localparam int RANK_W = 11;
  localparam int POS_W  = 10;
  localparam int REM_W  = 11;
  localparam int SLOT_W = 11;

  localparam logic [SLOT_W-1:0] SLOT_RST = 11'd1024;

  localparam logic OP_FILL   = 1'b0;
  localparam logic OP_SELECT = 1'b1;

  localparam int STEP_W = 4;

  localparam logic [STEP_W-1:0] S_WAIT      = 4'd0;
  localparam logic [STEP_W-1:0] S_DISPATCH  = 4'd1;
  localparam logic [STEP_W-1:0] S_DESC_INIT = 4'd2;
  localparam logic [STEP_W-1:0] S_DESC_RD   = 4'd3;
  localparam logic [STEP_W-1:0] S_DESC_STEP = 4'd4;
  localparam logic [STEP_W-1:0] S_REM_INIT  = 4'd5;
  localparam logic [STEP_W-1:0] S_REM_RD    = 4'd6;
  localparam logic [STEP_W-1:0] S_REM_WR    = 4'd7;
  localparam logic [STEP_W-1:0] S_FIN_SEL   = 4'd8;
  localparam logic [STEP_W-1:0] S_FILL_INIT = 4'd9;
  localparam logic [STEP_W-1:0] S_FILL_WR   = 4'd10;
  localparam logic [STEP_W-1:0] S_FIN_FILL  = 4'd11;
  localparam logic [STEP_W-1:0] S_FIN_ERR   = 4'd12;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_LATCH,
    ACT_DESC_INIT,
    ACT_DESC_RD,
    ACT_DESC_STEP,
    ACT_REM_INIT,
    ACT_REM_RD,
    ACT_REM_WR,
    ACT_FIN_SEL,
    ACT_FILL_INIT,
    ACT_FILL_WR,
    ACT_FIN_FILL,
    ACT_FIN_ERR
  } act_t;

  typedef enum logic [2:0] {
    JC_NEVER,
    JC_NOSTART,
    JC_FILL,
    JC_BAD,
    JC_DESC_MORE,
    JC_REM_MORE,
    JC_FILL_MORE,
    JC_ALWAYS
  } jc_t;

  typedef struct packed {
    act_t              act;
    jc_t               jc;
    logic [STEP_W-1:0] target;
  } uword_t;

  typedef struct packed {
    logic start;
    logic fill;
    logic bad;
    logic desc_more;
    logic rem_more;
    logic fill_more;
  } cond_t;

  function automatic uword_t ucode(input logic [STEP_W-1:0] step);
    uword_t uw;
    case (step)
      S_WAIT:      uw = '{ACT_LATCH,     JC_NOSTART,   S_WAIT};
      S_DISPATCH:  uw = '{ACT_NONE,      JC_FILL,      S_FILL_INIT};
      S_DESC_INIT: uw = '{ACT_DESC_INIT, JC_BAD,       S_FIN_ERR};
      S_DESC_RD:   uw = '{ACT_DESC_RD,   JC_NEVER,     S_WAIT};
      S_DESC_STEP: uw = '{ACT_DESC_STEP, JC_DESC_MORE, S_DESC_RD};
      S_REM_INIT:  uw = '{ACT_REM_INIT,  JC_NEVER,     S_WAIT};
      S_REM_RD:    uw = '{ACT_REM_RD,    JC_NEVER,     S_WAIT};
      S_REM_WR:    uw = '{ACT_REM_WR,    JC_REM_MORE,  S_REM_RD};
      S_FIN_SEL:   uw = '{ACT_FIN_SEL,   JC_ALWAYS,    S_WAIT};
      S_FILL_INIT: uw = '{ACT_FILL_INIT, JC_NEVER,     S_WAIT};
      S_FILL_WR:   uw = '{ACT_FILL_WR,   JC_FILL_MORE, S_FILL_WR};
      S_FIN_FILL:  uw = '{ACT_FIN_FILL,  JC_ALWAYS,    S_WAIT};
      S_FIN_ERR:   uw = '{ACT_FIN_ERR,   JC_ALWAYS,    S_WAIT};
      default:     uw = '{ACT_NONE,      JC_ALWAYS,    S_WAIT};
    endcase
    return uw;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/order_statistic_select_remove.sv =====
// Top level: Fenwick-tree order-statistic select/remove with microcoded control.
//
// Channel   Direction  Handshake              Payload
// cmd       in         start / busy           operation, rank
// result    out        done (1-cycle strobe)  position, error, remaining
// cfg       in         cfg_valid / cfg_ready  cfg_data (slot_count)
//
// Select: descent over the tree, then removal along a path of L <= log2(MAX_SLOTS) + 1
// entries, on the single-port tree RAM (one read per descent step, read+write per
// removal step). Fill: one tree entry written per cycle. Reset clears control only;
// tree RAM is not cleared, it is never read before the first fill since remaining
// is zero. Results cannot be stalled.
// cfg_ready is low while a transaction is in flight or being started.
`default_nettype none

module order_statistic_select_remove #(
  parameter int MAX_SLOTS = ossr_pkg::MAX_SLOTS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        operation,
  input  wire logic [ossr_pkg::RANK_W-1:0] rank,
  output logic                             done,
  output logic [ossr_pkg::POS_W-1:0]       position,
  output logic                             error,
  output logic [ossr_pkg::REM_W-1:0]       remaining,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [ossr_pkg::SLOT_W-1:0] cfg_data
);
  import ossr_pkg::*;

  localparam int PW = $clog2(MAX_SLOTS);
  localparam int CW = $clog2(MAX_SLOTS + 1);
  localparam int KW = (CW > SLOT_W) ? CW : SLOT_W;

  logic [CW-1:0] tree [MAX_SLOTS];

  logic [SLOT_W-1:0] slot_count;
  logic              op_q;
  logic [RANK_W-1:0] rank_q;
  logic [CW-1:0]     remaining_count;
  logic [CW-1:0]     nfill;
  logic [PW-1:0]     pos;
  logic [PW-1:0]     bitm;
  logic [CW-1:0]     remk;
  logic              in_rng;
  logic [PW:0]       idx;
  logic [CW-1:0]     rdata;
  logic [POS_W-1:0]  pos_out;
  logic              err_out;

  uword_t uw;
  cond_t  cond;
  logic   idle;

  logic [PW:0]   sum;
  logic [PW:0]   sum_m1;
  logic [PW:0]   idx_nx;
  logic [PW-1:0] fidx;
  logic [PW-1:0] lo_i;
  logic [CW-1:0] hi_i;
  logic [CW-1:0] fill_val;
  logic          we;
  logic [PW-1:0] raddr;
  logic [CW-1:0] wdata;

  ossr_useq u_useq (
    .clk   (clk),
    .rst   (rst),
    .cond  (cond),
    .uword (uw),
    .idle  (idle)
  );

  assign busy      = !idle;
  assign cfg_ready = idle && !start;
  assign position  = pos_out;
  assign error     = err_out;
  assign remaining = REM_W'(remaining_count);

  always_comb begin
    sum    = {1'b0, pos} + {1'b0, bitm};
    sum_m1 = sum - 1'b1;
    idx_nx = idx | (idx + 1'b1);
    fidx   = idx[PW-1:0];
    lo_i   = fidx & (fidx + 1'b1);
    hi_i   = (CW'(fidx) > nfill - 1'b1) ? nfill - 1'b1 : CW'(fidx);
    if (nfill == '0 || CW'(lo_i) >= nfill) begin
      fill_val = '0;
    end else begin
      fill_val = hi_i - CW'(lo_i) + 1'b1;
    end

    cond.start     = start;
    cond.fill      = (op_q == OP_FILL);
    cond.bad       = (rank_q == '0) || (KW'(rank_q) > KW'(remaining_count));
    cond.desc_more = !bitm[0];
    cond.rem_more  = (idx_nx < (PW+1)'(MAX_SLOTS));
    cond.fill_more = (fidx != PW'(MAX_SLOTS - 1));

    we    = (uw.act == ACT_FILL_WR) || (uw.act == ACT_REM_WR);
    raddr = (uw.act == ACT_DESC_RD) ? sum_m1[PW-1:0] : fidx;
    wdata = (uw.act == ACT_FILL_WR) ? fill_val : rdata - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      tree[fidx] <= wdata;
    end
    rdata <= tree[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count      <= SLOT_RST;
      remaining_count <= '0;
      done            <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        slot_count <= cfg_data;
      end
      case (uw.act)
        ACT_LATCH: begin
          op_q   <= operation;
          rank_q <= rank;
        end
        ACT_DESC_INIT: begin
          pos  <= '0;
          bitm <= PW'(1) << (PW - 1);
          remk <= CW'(rank_q);
        end
        ACT_DESC_RD: begin
          in_rng <= (sum <= (PW+1)'(MAX_SLOTS));
        end
        ACT_DESC_STEP: begin
          if (in_rng && rdata < remk) begin
            pos  <= sum[PW-1:0];
            remk <= remk - rdata;
          end
          bitm <= bitm >> 1;
        end
        ACT_REM_INIT: begin
          idx     <= {1'b0, pos};
          pos_out <= POS_W'(pos);
        end
        ACT_REM_WR: begin
          idx <= idx_nx;
        end
        ACT_FIN_SEL: begin
          remaining_count <= remaining_count - 1'b1;
          err_out         <= 1'b0;
          done            <= 1'b1;
        end
        ACT_FILL_INIT: begin
          idx   <= '0;
          nfill <= (KW'(slot_count) > KW'(MAX_SLOTS)) ? CW'(MAX_SLOTS) : CW'(slot_count);
        end
        ACT_FILL_WR: begin
          idx <= idx + 1'b1;
        end
        ACT_FIN_FILL: begin
          remaining_count <= nfill;
          pos_out         <= '0;
          err_out         <= 1'b0;
          done            <= 1'b1;
        end
        ACT_FIN_ERR: begin
          pos_out <= '0;
          err_out <= 1'b1;
          done    <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while sequencer busy");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not start the sequencer");

  a_err_pos: assert property (@(posedge clk) disable iff (rst)
    (done && error) |-> (position == '0))
    else $error("error result with nonzero position");

  a_rem_max: assert property (@(posedge clk) disable iff (rst)
    remaining_count <= CW'(MAX_SLOTS))
    else $error("remaining count above table size");

endmodule

`default_nettype wire

// ===== hdl/ossr_useq.sv =====
// Microcode sequencer: step counter, control ROM and conditional jumps.
`default_nettype none

module ossr_useq (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire ossr_pkg::cond_t cond,
  output ossr_pkg::uword_t     uword,
  output logic                 idle
);
  import ossr_pkg::*;

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  logic              take;

  assign uword = ucode(step);
  assign idle  = (step == S_WAIT);

  always_comb begin
    case (uword.jc)
      JC_NEVER:     take = 1'b0;
      JC_NOSTART:   take = !cond.start;
      JC_FILL:      take = cond.fill;
      JC_BAD:       take = cond.bad;
      JC_DESC_MORE: take = cond.desc_more;
      JC_REM_MORE:  take = cond.rem_more;
      JC_FILL_MORE: take = cond.fill_more;
      JC_ALWAYS:    take = 1'b1;
      default:      take = 1'b1;
    endcase
    step_next = take ? uword.target : step + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_WAIT;
    end else begin
      step <= step_next;
    end
  end

endmodule

`default_nettype wire
